### design/hmn_pkg.sv
package hmn_pkg;

    // Fixed field widths
    localparam int HEIGHT_W   = 16;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;
    localparam int GRID_W     = 9;
    localparam int ZW         = 24;
    localparam int DW         = 25;
    localparam int SQW        = 2 * DW;
    localparam int RTW        = DW;
    localparam int RMW        = RTW + 3;
    localparam int SQRT_STEPS = RTW;
    localparam int NDW        = 40;
    localparam int QW         = 15;
    localparam int DIV_STEPS  = QW;
    localparam int OUT_W      = 88;
    localparam int PIPE_DRAIN = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_HEIGHT_SCALE = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS    = 2'd1;
    localparam logic [IDX_W-1:0] REG_GRID_ROWS    = 2'd2;

    localparam logic [CFG_W-1:0] SCALE_RESET = 16'd5120;
    localparam int               GRID_RESET  = 256;

    // Neighbor read slots
    localparam int         NUM_SLOTS = 5;
    localparam logic [2:0] SLOT_C    = 3'd0;
    localparam logic [2:0] SLOT_XP   = 3'd1;
    localparam logic [2:0] SLOT_XM   = 3'd2;
    localparam logic [2:0] SLOT_YP   = 3'd3;
    localparam logic [2:0] SLOT_YM   = 3'd4;

    typedef struct packed {
        logic       accept;
        logic       wrap;
        logic       div_start;
        logic       div_step;
        logic       div_done;
        logic       store;
        logic       rd;
        logic [2:0] slot;
        logic       diff;
        logic       sq;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       ndiv_init;
        logic       ndiv_step;
        logic       out_load;
    } hmn_cmd_t;

    typedef struct packed {
        logic mode;
        logic resync;
        logic out_free;
    } hmn_stat_t;

endpackage

### design/hmn_controller.sv
module hmn_controller #(
    parameter int DIV_W = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  hmn_pkg::hmn_stat_t stat,
    output hmn_pkg::hmn_cmd_t  cmd
);
    import hmn_pkg::*;

    localparam int MAX_STEPS = (DIV_W > SQRT_STEPS) ? DIV_W : SQRT_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_RESYNC = 4'd2;
    localparam logic [3:0] S_FIX    = 4'd3;
    localparam logic [3:0] S_LOAD   = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_DIFF   = 4'd7;
    localparam logic [3:0] S_SQ     = 4'd8;
    localparam logic [3:0] S_SQRT0  = 4'd9;
    localparam logic [3:0] S_SQRT   = 4'd10;
    localparam logic [3:0] S_NDIV0  = 4'd11;
    localparam logic [3:0] S_NDIV   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       dispatch;

    assign s_tready = (state_reg == S_IDLE);
    assign dispatch = stat.mode ? S_RD : S_LOAD;

    // Sequence the datapath
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.wrap      = 1'b1;
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = stat.resync ? S_RESYNC : dispatch;
            end
            S_RESYNC:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.div_done = 1'b1;
                cnt_next     = '0;
                state_next   = dispatch;
            end
            S_LOAD:
            begin
                cmd.store  = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                cmd.rd   = 1'b1;
                cmd.slot = cnt_reg[2:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PIPE_DRAIN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_SQRT0;
            end
            S_SQRT0:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_NDIV0;
                end
            end
            S_NDIV0:
            begin
                cmd.ndiv_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_NDIV;
            end
            S_NDIV:
            begin
                cmd.ndiv_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### design/hmn_datapath.sv
module hmn_datapath #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256,
    parameter int DIV_W    = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hmn_pkg::hmn_cmd_t             cmd,
    output hmn_pkg::hmn_stat_t            stat,
    input  logic [hmn_pkg::HEIGHT_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hmn_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [hmn_pkg::IDX_W-1:0]     cfg_index,
    input  logic [hmn_pkg::CFG_W-1:0]     cfg_data
);
    import hmn_pkg::*;

    localparam int CW       = $clog2(MAX_COLS);
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW1      = $clog2(MAX_COLS + 1);
    localparam int RW1      = $clog2(MAX_ROWS + 1);
    localparam int PW       = DIV_W;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int AW       = $clog2(DEPTH);
    localparam int COLS_RST = (GRID_RESET > MAX_COLS) ? MAX_COLS : GRID_RESET;
    localparam int ROWS_RST = (GRID_RESET > MAX_ROWS) ? MAX_ROWS : GRID_RESET;

    // Configuration
    logic [CFG_W-1:0]  scale_reg;
    logic [CW1-1:0]    cols_reg, cols_cl;
    logic [RW1-1:0]    rows_reg, rows_cl;
    logic [PW-1:0]     total_reg;
    logic              resync_reg;
    logic [GRID_W-1:0] grid_in;

    // Item and positions
    logic                mode_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PW-1:0]       lpos_reg, epos_reg, lpos_w, epos_w;
    logic [CW-1:0]       lcol_reg, ecol_reg;
    logic [RW-1:0]       lrow_reg, erow_reg;
    logic                l_end, e_end, l_rowend, e_rowend;

    // Resync dividers
    logic [PW-1:0]  ldn_reg, lq_reg, edn_reg, eq_reg;
    logic [RW1-1:0] lr_reg, er_reg;
    logic [RW1:0]   lr2, er2;
    logic           lge, ege;

    // Frame store and read pipeline
    logic [HEIGHT_W-1:0] mem [DEPTH];
    logic [HEIGHT_W-1:0] rdata_reg;
    logic [AW-1:0]       laddr, raddr;
    logic [CW-1:0]       cm, cp;
    logic [RW-1:0]       rm, rp;
    logic                v1_reg, v2_reg;
    logic [2:0]          s1_reg, s2_reg;
    logic signed [32:0]  prod_reg, hx, sx, psum, zsh;
    logic signed [ZW-1:0] zsat;
    logic signed [ZW-1:0] z_reg [NUM_SLOTS];

    // Normal arithmetic
    logic signed [DW-1:0]  dx_reg, dy_reg;
    logic signed [SQW-1:0] px, py;
    logic [SQW-1:0]        sqx_reg, sqy_reg, src_reg;
    logic [RTW-1:0]        root_reg;
    logic [RMW-1:0]        rem_reg, rem2, trial;
    logic [NDW-1:0]        nx_reg, ny_reg, nz_reg, dsh_reg;
    logic [QW-1:0]         qx_reg, qy_reg, qz_reg;
    logic [DW-1:0]         magx, magy;
    logic [15:0]           nx_out, ny_out;
    logic                  last;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
        logic [AW-1:0] a;
        a = AW'(c) * AW'(MAX_ROWS) + AW'(r);
        return a;
    endfunction

    // Clamp grid sizes into range
    assign grid_in = cfg_data[GRID_W-1:0];
    always_comb
    begin
        if (grid_in == '0)
            cols_cl = CW1'(1);
        else if (32'(grid_in) > MAX_COLS)
            cols_cl = CW1'(MAX_COLS);
        else
            cols_cl = CW1'(grid_in);
        if (grid_in == '0)
            rows_cl = RW1'(1);
        else if (32'(grid_in) > MAX_ROWS)
            rows_cl = RW1'(MAX_ROWS);
        else
            rows_cl = RW1'(grid_in);
    end

    // Register writes; a grid change forces a position resync
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            cols_reg   <= CW1'(COLS_RST);
            rows_reg   <= RW1'(ROWS_RST);
            total_reg  <= PW'(COLS_RST * ROWS_RST);
            resync_reg <= 1'b0;
        end
        else
        begin
            total_reg <= PW'(cols_reg) * PW'(rows_reg);
            if (cmd.div_done)
                resync_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEIGHT_SCALE: scale_reg <= cfg_data;
                    REG_GRID_COLS:
                    begin
                        cols_reg   <= cols_cl;
                        resync_reg <= 1'b1;
                    end
                    REG_GRID_ROWS:
                    begin
                        rows_reg   <= rows_cl;
                        resync_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cmd.accept)
            mode_reg <= s_tuser;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            height_reg <= s_tdata;
    end

    // Position bookkeeping
    assign lpos_w   = (lpos_reg >= total_reg) ? '0 : lpos_reg;
    assign epos_w   = (epos_reg >= total_reg) ? '0 : epos_reg;
    assign l_end    = ({1'b0, lpos_reg} + 1'b1) == {1'b0, total_reg};
    assign e_end    = ({1'b0, epos_reg} + 1'b1) == {1'b0, total_reg};
    assign l_rowend = ((RW1 + 1)'(lrow_reg) + 1'b1) == (RW1 + 1)'(rows_reg);
    assign e_rowend = ((RW1 + 1)'(erow_reg) + 1'b1) == (RW1 + 1)'(rows_reg);
    assign last     = e_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpos_reg <= '0;
            lcol_reg <= '0;
            lrow_reg <= '0;
            epos_reg <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else
        begin
            if (cmd.wrap)
            begin
                lpos_reg <= lpos_w;
                epos_reg <= epos_w;
                if (lpos_reg >= total_reg)
                begin
                    lcol_reg <= '0;
                    lrow_reg <= '0;
                end
                if (epos_reg >= total_reg)
                begin
                    ecol_reg <= '0;
                    erow_reg <= '0;
                end
            end
            if (cmd.div_done)
            begin
                lcol_reg <= CW'(lq_reg);
                lrow_reg <= RW'(lr_reg);
                ecol_reg <= CW'(eq_reg);
                erow_reg <= RW'(er_reg);
            end
            if (cmd.store)
            begin
                if (l_end)
                begin
                    lpos_reg <= '0;
                    lcol_reg <= '0;
                    lrow_reg <= '0;
                end
                else
                begin
                    lpos_reg <= lpos_reg + 1'b1;
                    if (l_rowend)
                    begin
                        lrow_reg <= '0;
                        lcol_reg <= lcol_reg + 1'b1;
                    end
                    else
                        lrow_reg <= lrow_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                if (e_end)
                begin
                    epos_reg <= '0;
                    ecol_reg <= '0;
                    erow_reg <= '0;
                end
                else
                begin
                    epos_reg <= epos_reg + 1'b1;
                    if (e_rowend)
                    begin
                        erow_reg <= '0;
                        ecol_reg <= ecol_reg + 1'b1;
                    end
                    else
                        erow_reg <= erow_reg + 1'b1;
                end
            end
        end
    end

    // Split linear positions into column and row, one bit a cycle
    assign lr2 = {lr_reg, ldn_reg[PW-1]};
    assign er2 = {er_reg, edn_reg[PW-1]};
    assign lge = lr2 >= (RW1 + 1)'(rows_reg);
    assign ege = er2 >= (RW1 + 1)'(rows_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            ldn_reg <= lpos_w;
            edn_reg <= epos_w;
            lq_reg  <= '0;
            eq_reg  <= '0;
            lr_reg  <= '0;
            er_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            ldn_reg <= ldn_reg << 1;
            edn_reg <= edn_reg << 1;
            lq_reg  <= {lq_reg[PW-2:0], lge};
            eq_reg  <= {eq_reg[PW-2:0], ege};
            lr_reg  <= lge ? RW1'(lr2 - (RW1 + 1)'(rows_reg)) : RW1'(lr2);
            er_reg  <= ege ? RW1'(er2 - (RW1 + 1)'(rows_reg)) : RW1'(er2);
        end
    end

    // Wrapped neighbor coordinates
    always_comb
    begin
        cm = (ecol_reg == '0) ? CW'(cols_reg - 1'b1) : ecol_reg - 1'b1;
        cp = (((CW1 + 1)'(ecol_reg) + 1'b1) >= (CW1 + 1)'(cols_reg)) ? '0 : ecol_reg + 1'b1;
        rm = (erow_reg == '0) ? RW'(rows_reg - 1'b1) : erow_reg - 1'b1;
        rp = (((RW1 + 1)'(erow_reg) + 1'b1) >= (RW1 + 1)'(rows_reg)) ? '0 : erow_reg + 1'b1;
    end

    assign laddr = addr_of(lcol_reg, lrow_reg);

    always_comb
    begin
        case (cmd.slot)
            SLOT_C:  raddr = addr_of(ecol_reg, erow_reg);
            SLOT_XP: raddr = addr_of(cp, erow_reg);
            SLOT_XM: raddr = addr_of(cm, erow_reg);
            SLOT_YP: raddr = addr_of(ecol_reg, rp);
            SLOT_YM: raddr = addr_of(ecol_reg, rm);
            default: raddr = addr_of(ecol_reg, erow_reg);
        endcase
    end

    // Frame store: one access a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[laddr] <= height_reg;
        if (cmd.rd)
            rdata_reg <= mem[raddr];
    end

    // Scale pipeline: read, multiply, round and saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd;
            v2_reg <= v1_reg;
        end
    end

    assign hx   = 33'($signed(rdata_reg));
    assign sx   = $signed({17'b0, scale_reg});
    assign psum = prod_reg + 33'sd128;
    assign zsh  = psum >>> 8;

    always_comb
    begin
        if (zsh > 33'sd8388607)
            zsat = 24'sh7FFFFF;
        else if (zsh < -33'sd8388608)
            zsat = 24'sh800000;
        else
            zsat = ZW'(zsh);
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= cmd.slot;
        s2_reg <= s1_reg;
        if (v1_reg)
            prod_reg <= hx * sx;
        if (v2_reg)
            z_reg[s2_reg] <= zsat;
    end

    // Differences, squares and the integer square root
    assign px    = dx_reg * dx_reg;
    assign py    = dy_reg * dy_reg;
    assign rem2  = {rem_reg[RMW-3:0], src_reg[SQW-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= DW'(z_reg[SLOT_XP]) - DW'(z_reg[SLOT_XM]);
            dy_reg <= DW'(z_reg[SLOT_YP]) - DW'(z_reg[SLOT_YM]);
        end
        if (cmd.sq)
        begin
            sqx_reg <= $unsigned(px);
            sqy_reg <= $unsigned(py);
        end
        if (cmd.sqrt_init)
        begin
            src_reg  <= sqx_reg + sqy_reg + (SQW'(1) << 26);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            src_reg <= src_reg << 2;
            if (rem2 >= trial)
            begin
                rem_reg  <= rem2 - trial;
                root_reg <= {root_reg[RTW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem2;
                root_reg <= {root_reg[RTW-2:0], 1'b0};
            end
        end
    end

    // Component division, rounded half away from zero
    assign magx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign magy = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.ndiv_init)
        begin
            dsh_reg <= {root_reg, 15'b0};
            nx_reg  <= (NDW'(magx) << 15) + NDW'(root_reg);
            ny_reg  <= (NDW'(magy) << 15) + NDW'(root_reg);
            nz_reg  <= (NDW'(8192) << 15) + NDW'(root_reg);
            qx_reg  <= '0;
            qy_reg  <= '0;
            qz_reg  <= '0;
        end
        else if (cmd.ndiv_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            nx_reg  <= (nx_reg >= dsh_reg) ? nx_reg - dsh_reg : nx_reg;
            ny_reg  <= (ny_reg >= dsh_reg) ? ny_reg - dsh_reg : ny_reg;
            nz_reg  <= (nz_reg >= dsh_reg) ? nz_reg - dsh_reg : nz_reg;
            qx_reg  <= {qx_reg[QW-2:0], nx_reg >= dsh_reg};
            qy_reg  <= {qy_reg[QW-2:0], ny_reg >= dsh_reg};
            qz_reg  <= {qz_reg[QW-2:0], nz_reg >= dsh_reg};
        end
    end

    // Normal points against the slope
    assign nx_out = (!dx_reg[DW-1] && dx_reg != '0) ? 16'd0 - 16'(qx_reg) : 16'(qx_reg);
    assign ny_out = (!dy_reg[DW-1] && dy_reg != '0) ? 16'd0 - 16'(qy_reg) : 16'(qy_reg);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (cmd.out_load)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata <= {1'b0, qz_reg, ny_out, nx_out, z_reg[SLOT_C],
                        8'(erow_reg), 8'(ecol_reg)};
            m_tlast <= last;
        end
    end

    assign stat.mode     = mode_reg;
    assign stat.resync   = resync_reg;
    assign stat.out_free = !m_tvalid || m_tready;

endmodule

### design/heightmap_normal_generator.sv
// Height grid to mesh vertex generator. A transaction with tuser 0 stores one
// Q4.12 height sample at the next grid position (column by column); one with
// tuser 1 yields the next vertex with its scaled height and a unit normal
// from central differences of the four wrapped neighbors. Items are handled
// one at a time. A vertex takes five reads from the single-port frame store,
// a 25-step bit-serial square root and a 15-step divider for the normal
// components. The first item after a grid_cols or grid_rows write first
// re-splits the stored positions into column and row. A finished vertex
// waits in the output register while the next item is accepted.
module heightmap_normal_generator #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hmn_pkg::HEIGHT_W-1:0] s_tdata,   // height[15:0]
    input  logic                         s_tuser,   // mode[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // col_index[7:0], row_index[15:8], pos_z[39:16], normal_x[55:40],
    // normal_y[71:56], normal_z[86:72], zero[87]
    output logic [hmn_pkg::OUT_W-1:0]    m_tdata,
    output logic                         m_tlast,   // last_vertex
    input  logic                         cfg_we,
    input  logic [hmn_pkg::IDX_W-1:0]    cfg_index,
    input  logic [hmn_pkg::CFG_W-1:0]    cfg_data
);
    import hmn_pkg::*;

    localparam int DIV_W = $clog2(MAX_COLS * MAX_ROWS + 1);

    hmn_cmd_t  cmd;
    hmn_stat_t stat;

    hmn_controller #(
        .DIV_W (DIV_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hmn_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .DIV_W    (DIV_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### design/hmn_checker.sv
module hmn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Normal z stays within one in Q1.14
    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[86:72] <= 15'd16384)
        else $error("normal z out of range");

    // One item at a time: ready drops after each transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind heightmap_normal_generator hmn_checker u_hmn_checker (.*);
